>>> hw/rtl/dsrm_pkg.sv
// shared types and constants for the dot-star regex matcher
package dsrm_pkg;

	localparam int PATTERN_MAX_DEF = 32;

	localparam logic [7:0] SYM_DOT  = 8'd46;
	localparam logic [7:0] SYM_STAR = 8'd42;

	localparam logic [1:0] KIND_PATTERN = 2'd0;
	localparam logic [1:0] KIND_START   = 2'd1;
	localparam logic [1:0] KIND_TEXT    = 2'd2;

	localparam logic [1:0] STATUS_OK          = 2'd0;
	localparam logic [1:0] STATUS_TOO_LONG    = 2'd1;
	localparam logic [1:0] STATUS_LEADING_STAR = 2'd2;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] symbol;
		logic       last;
	} item_t;

	typedef struct packed {
		logic       matched;
		logic [1:0] status;
	} result_t;

	// row control broadcast to every cell
	typedef struct packed {
		logic       clear;
		logic       start;
		logic       step;
		logic [7:0] sym;
	} row_ctrl_t;

endpackage

>>> hw/rtl/dsrm_cell.sv
// one pattern element: stored byte, dot and star flags, and its row bit
module dsrm_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  dsrm_pkg::row_ctrl_t ctrl,
	input  logic               en,
	input  logic               wr,
	input  logic [7:0]         wr_byte,
	input  logic               set_star,
	input  logic               chain_in,
	input  logic               row_prev,
	output logic               chain_out,
	output logic               row_q
);
	import dsrm_pkg::*;

	logic [7:0] byte_q;
	logic       dot_q;
	logic       star_q;
	logic       hit;
	logic       row_nxt;

	always_ff @(posedge clk) begin
		if (wr) begin
			byte_q <= wr_byte;
			dot_q  <= (wr_byte == SYM_DOT);
			star_q <= 1'b0;
		end else if (set_star) begin
			star_q <= 1'b1;
		end
	end

	assign hit = dot_q || (byte_q == ctrl.sym);

	always_comb begin
		row_nxt = row_q;
		if (ctrl.clear) begin
			row_nxt = 1'b0;
		end else if (ctrl.start) begin
			// zero-occurrence closure ripples through starred cells
			row_nxt = en && chain_in && star_q;
		end else if (ctrl.step) begin
			if (!en)
				row_nxt = 1'b0;
			else if (star_q)
				row_nxt = chain_in || (hit && row_q);
			else
				row_nxt = hit && row_prev;
		end
	end

	assign chain_out = row_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			row_q <= 1'b0;
		else
			row_q <= row_nxt;
	end

endmodule

>>> hw/rtl/dot_star_regex_matcher_top.sv
// top level of the dot-star regex matcher: control, cell chain and result register
// Matches a streamed byte string against a pattern of literals, dot (any
// byte) and star (previous element repeats zero or more times).
// Input channel item_valid/item_ready/item carries kind, symbol and last.
// A pattern character (kind 0) is stored in the next cell of the chain; a
// star marks the previous cell. A pattern character after a closed pattern
// begins a new pattern. Start of text (kind 1) and each text byte (kind 2)
// give one result on result_valid/result_ready/result: matched and status.
// Kinds 0 and 3 give no result.
// One item is taken per cycle unless a stalled result holds the input. A result
// appears in the cycle after its item is accepted; the row update is one pass
// through the cell chain, where star closure ripples cell to cell like a carry.
// The result register lets a new item in while a result waits, as long as
// the receiver takes it in the same cycle; a stalled result holds and the
// input stalls with it.
// Reset clears the element count, status, closure flag and the whole row;
// the element storage is written only by pattern loading.
module dot_star_regex_matcher_top #(
	parameter int PATTERN_MAX = dsrm_pkg::PATTERN_MAX_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  dsrm_pkg::item_t   item,
	output logic              result_valid,
	input  logic              result_ready,
	output dsrm_pkg::result_t result
);
	import dsrm_pkg::*;

	localparam int CW = $clog2(PATTERN_MAX + 1);

	logic [CW-1:0]        count_q;
	logic                 closed_q;
	logic [1:0]           status_q;
	logic                 row0_q;
	logic                 result_valid_q;
	result_t              result_q;

	logic                 accept;
	logic                 is_pat, is_start, is_text;
	logic [CW-1:0]        count_eff;
	logic [1:0]           status_eff;
	logic                 is_star;
	logic                 row0_nxt;
	row_ctrl_t            ctrl;
	logic [PATTERN_MAX:0] row;
	logic [PATTERN_MAX:0] row_nxt;
	logic [PATTERN_MAX-1:0] wr;
	logic [PATTERN_MAX-1:0] set_star;
	logic [PATTERN_MAX-1:0] en;

	assign item_ready = !result_valid_q || result_ready;
	assign accept     = item_valid && item_ready;

	always_comb begin
		is_pat   = 1'b0;
		is_start = 1'b0;
		is_text  = 1'b0;
		unique case (item.kind)
			KIND_PATTERN: is_pat   = accept;
			KIND_START:   is_start = accept;
			KIND_TEXT:    is_text  = accept;
			default: ;
		endcase
	end

	// a closed pattern restarts on the next pattern character
	assign count_eff  = closed_q ? '0 : count_q;
	assign status_eff = closed_q ? STATUS_OK : status_q;
	assign is_star    = (item.symbol == SYM_STAR);

	assign ctrl.clear = is_pat && closed_q;
	assign ctrl.start = is_start;
	assign ctrl.step  = is_text;
	assign ctrl.sym   = item.symbol;

	always_comb begin
		row0_nxt = row0_q;
		if (ctrl.clear || ctrl.step)
			row0_nxt = 1'b0;
		else if (ctrl.start)
			row0_nxt = 1'b1;
	end

	assign row[0]     = row0_q;
	assign row_nxt[0] = row0_nxt;

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		assign en[i]       = (CW'(i) < count_q);
		assign wr[i]       = is_pat && !is_star && (count_eff == CW'(i));
		assign set_star[i] = is_pat && is_star && (count_eff == CW'(i + 1));

		dsrm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl      (ctrl),
			.en        (en[i]),
			.wr        (wr[i]),
			.wr_byte   (item.symbol),
			.set_star  (set_star[i]),
			.chain_in  (row_nxt[i]),
			.row_prev  (row[i]),
			.chain_out (row_nxt[i+1]),
			.row_q     (row[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			closed_q <= 1'b0;
			status_q <= STATUS_OK;
			row0_q   <= 1'b0;
		end else begin
			row0_q <= row0_nxt;
			if (is_pat) begin
				closed_q <= item.last;
				if (is_star) begin
					count_q <= count_eff;
					if (count_eff == '0 && status_eff == STATUS_OK)
						status_q <= STATUS_LEADING_STAR;
					else
						status_q <= status_eff;
				end else if (count_eff == CW'(PATTERN_MAX)) begin
					count_q <= count_eff;
					if (status_eff == STATUS_OK)
						status_q <= STATUS_TOO_LONG;
					else
						status_q <= status_eff;
				end else begin
					count_q  <= count_eff + CW'(1);
					status_q <= status_eff;
				end
			end else if (is_start || is_text) begin
				closed_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (is_start || is_text)
			result_valid_q <= 1'b1;
		else if (result_ready)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (is_start || is_text) begin
			result_q.matched <= (status_q == STATUS_OK) && row_nxt[count_q];
			result_q.status  <= status_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

>>> test/tb.sv
// testbench for the dot-star regex matcher: random pattern and text items against a scoreboard
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dsrm_pkg::*;

	class match_scoreboard;
		localparam int PMAX = dsrm_pkg::PATTERN_MAX_DEF;

		logic [7:0]  elem_byte [PMAX];
		bit          elem_dot [PMAX];
		bit          elem_star [PMAX];
		int unsigned elem_count;
		bit          closed;
		logic [1:0]  status;
		bit [PMAX:0] row;
		result_t     expected_q [$];
		int          errors;

		function new();
			elem_count = 0;
			closed = 1'b0;
			status = STATUS_OK;
			row = '0;
			errors = 0;
		endfunction

		function void flag_status(logic [1:0] code);
			// the first error sticks
			if (status == STATUS_OK)
				status = code;
		endfunction

		function void note_item(item_t it);
			result_t     r;
			bit [PMAX:0] nxt;
			bit          hit;
			case (it.kind)
				KIND_PATTERN: begin
					if (closed) begin
						elem_count = 0;
						status = STATUS_OK;
						closed = 1'b0;
						row = '0;
					end
					if (it.symbol == SYM_STAR) begin
						if (elem_count == 0)
							flag_status(STATUS_LEADING_STAR);
						else
							elem_star[elem_count - 1] = 1'b1;
					end else if (elem_count >= PMAX) begin
						flag_status(STATUS_TOO_LONG);
					end else begin
						elem_byte[elem_count] = it.symbol;
						elem_dot[elem_count] = (it.symbol == SYM_DOT);
						elem_star[elem_count] = 1'b0;
						elem_count++;
					end
					if (it.last)
						closed = 1'b1;
				end
				KIND_START, KIND_TEXT: begin
					closed = 1'b1;
					if (it.kind == KIND_START) begin
						// empty text plus closure through leading starred elements
						row = '0;
						row[0] = 1'b1;
						for (int j = 1; j <= elem_count; j++)
							row[j] = row[j - 1] & elem_star[j - 1];
					end else begin
						nxt = '0;
						for (int j = 1; j <= elem_count; j++) begin
							hit = elem_dot[j - 1] || (elem_byte[j - 1] == it.symbol);
							if (elem_star[j - 1])
								nxt[j] = nxt[j - 1] | (hit & row[j]);
							else
								nxt[j] = hit & row[j - 1];
						end
						row = nxt;
					end
					r.matched = (status == STATUS_OK) && row[elem_count];
					r.status = status;
					expected_q.push_back(r);
				end
				default: ;
			endcase
		endfunction

		function void check_result(result_t got);
			result_t exp;
			if (expected_q.size() == 0) begin
				$error("result with no item pending: matched %0d status %0d",
					got.matched, got.status);
				errors++;
				return;
			end
			exp = expected_q.pop_front();
			if (got.matched !== exp.matched) begin
				$error("matched: expected %0d, actual %0d", exp.matched, got.matched);
				errors++;
			end
			if (got.status !== exp.status) begin
				$error("status: expected %0d, actual %0d", exp.status, got.status);
				errors++;
			end
		endfunction
	endclass

	localparam logic [1:0] KIND_UNUSED = 2'd3;
	localparam int QUIET_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 1500;
	localparam int CALM_TAIL = 250;

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	match_scoreboard sb = new();
	bit idling = 1'b1;
	int items_sent = 0;
	int stall_left = 0;
	int quiet_cycles = 0;

	dot_star_regex_matcher_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// monitor both channels, feed the scoreboard, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready)
				sb.check_result(result);
			if (item_valid && item_ready)
				sb.note_item(item);
			if ((item_valid && item_ready) || (result_valid && result_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// result side back-pressure in bursts
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (idling && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(1, 13) - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
		end
	end

	task automatic send_item(input logic [1:0] kind, input logic [7:0] symbol, input logic last);
		if (idling && $urandom_range(0, 5) == 0) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= '{kind: kind, symbol: symbol, last: last};
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		if (kind != KIND_UNUSED)
			items_sent++;
	endtask

	function automatic logic [7:0] text_symbol();
		if ($urandom_range(0, 4) == 0)
			return 8'($urandom_range(0, 255));
		return 8'h61 + 8'($urandom_range(0, 2));
	endfunction

	// one pattern followed by one to three texts, about half of them built to match
	task automatic pattern_run();
		logic [7:0] elem_sym [$];
		int         elem_stars [$];
		logic [7:0] chars [$];
		int         n_elem;
		int         choice;
		int         reps;
		logic [7:0] s;
		bit         give_last;
		if ($urandom_range(0, 19) == 0)
			n_elem = $urandom_range(30, 35);
		else
			n_elem = $urandom_range(1, 6);
		for (int i = 0; i < n_elem; i++) begin
			choice = $urandom_range(0, 9);
			if (choice < 5)
				s = 8'h61 + 8'($urandom_range(0, 2));
			else if (choice < 7)
				s = SYM_DOT;
			else
				s = 8'($urandom_range(0, 255));
			if (s == SYM_STAR)
				s = SYM_DOT;
			elem_sym.push_back(s);
			elem_stars.push_back(($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0);
		end
		if ($urandom_range(0, 19) == 0)
			chars.push_back(SYM_STAR);
		for (int i = 0; i < n_elem; i++) begin
			chars.push_back(elem_sym[i]);
			repeat (elem_stars[i])
				chars.push_back(SYM_STAR);
		end
		// sometimes leave the pattern open so the text closes it
		give_last = ($urandom_range(0, 9) != 0);
		foreach (chars[i])
			send_item(KIND_PATTERN, chars[i], give_last && (i == chars.size() - 1));

		repeat ($urandom_range(1, 3)) begin
			if ($urandom_range(0, 9) != 0)
				send_item(KIND_START, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 1) == 0) begin
				for (int i = 0; i < n_elem; i++) begin
					reps = (elem_stars[i] != 0) ? $urandom_range(0, 3) : 1;
					repeat (reps)
						send_item(KIND_TEXT,
							(elem_sym[i] == SYM_DOT) ? 8'($urandom_range(0, 255)) : elem_sym[i],
							1'($urandom_range(0, 1)));
				end
				if ($urandom_range(0, 3) == 0)
					send_item(KIND_TEXT, text_symbol(), 1'($urandom_range(0, 1)));
			end else begin
				repeat ($urandom_range(0, 8))
					send_item(KIND_TEXT, text_symbol(), 1'($urandom_range(0, 1)));
			end
			if ($urandom_range(0, 7) == 0)
				send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		int base;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// text with no start right after reset, then an unused kind
		send_item(KIND_TEXT, 8'h61, 1'b0);
		send_item(KIND_UNUSED, 8'hFF, 1'b1);
		// leading star sticks even after a good element
		send_item(KIND_PATTERN, SYM_STAR, 1'b0);
		send_item(KIND_PATTERN, 8'h61, 1'b1);
		send_item(KIND_START, 8'h00, 1'b0);
		// new pattern after closure: a, double star, dot, 0xff
		send_item(KIND_PATTERN, 8'h61, 1'b0);
		send_item(KIND_PATTERN, SYM_STAR, 1'b0);
		send_item(KIND_PATTERN, SYM_STAR, 1'b0);
		send_item(KIND_PATTERN, SYM_DOT, 1'b0);
		send_item(KIND_PATTERN, 8'hFF, 1'b1);
		send_item(KIND_START, 8'hFF, 1'b1);
		send_item(KIND_TEXT, 8'h61, 1'b0);
		send_item(KIND_TEXT, 8'h61, 1'b1);
		send_item(KIND_TEXT, 8'h00, 1'b0);
		send_item(KIND_TEXT, 8'hFF, 1'b0);
		// open pattern closed by the start of text
		send_item(KIND_PATTERN, 8'h78, 1'b0);
		send_item(KIND_START, 8'h78, 1'b0);
		send_item(KIND_TEXT, 8'h78, 1'b0);
		// new pattern, text with no start on a cleared row
		send_item(KIND_PATTERN, 8'h79, 1'b1);
		send_item(KIND_TEXT, 8'h79, 1'b0);
		// starred element matches the empty text
		send_item(KIND_PATTERN, 8'h61, 1'b0);
		send_item(KIND_PATTERN, SYM_STAR, 1'b1);
		send_item(KIND_START, 8'h00, 1'b0);
		send_item(KIND_TEXT, 8'h62, 1'b0);

		base = items_sent;
		while (items_sent - base < RANDOM_ITEMS) begin
			idling = (items_sent - base < RANDOM_ITEMS - CALM_TAIL);
			pattern_run();
		end
		idling = 1'b0;
		item_valid <= 1'b0;

		@(posedge clk);
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
